[src/ssfe_pkg.sv]
// Shared types, constants and the character-to-segment decoder of the text frame encoder.
package ssfe_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned FRAME_W = 36;

  localparam logic [CHAR_W-1:0] PERIOD_CODE = 8'h2E;
  localparam logic [SEG_W-1:0]  POINT_SEG   = 8'h01;
  localparam logic [SEG_W-1:0]  BLANK_SEG   = 8'h00;

  localparam logic CFG_AN1 = 1'b0;
  localparam logic CFG_AN2 = 1'b1;

  // One accepted text beat as handed from the port logic to the digit store.
  typedef struct packed {
    logic              load;
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } cmd_t;

  // Segment byte for a character: segments a..g in bits 7..1, point in bit 0.
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CHAR_W-1:0] code);
    logic [SEG_W-1:0] seg;
    unique case (code)
      8'h20: seg = 8'h00; // space
      8'h30: seg = 8'hFC; // 0
      8'h31: seg = 8'h60; // 1
      8'h32: seg = 8'hDA; // 2
      8'h33: seg = 8'hF2; // 3
      8'h34: seg = 8'h66; // 4
      8'h35: seg = 8'hB6; // 5
      8'h36: seg = 8'hBE; // 6
      8'h37: seg = 8'hE0; // 7
      8'h38: seg = 8'hFE; // 8
      8'h39: seg = 8'hE6; // 9
      8'h41: seg = 8'hEE; // A
      8'h42: seg = 8'hFE; // B
      8'h43: seg = 8'h9C; // C
      8'h44: seg = 8'hFC; // D
      8'h45: seg = 8'h9E; // E
      8'h46: seg = 8'h8E; // F
      8'h47: seg = 8'hBC; // G
      8'h48: seg = 8'h6E; // H
      8'h49: seg = 8'h60; // I
      8'h4A: seg = 8'h70; // J
      8'h4B: seg = 8'h6E; // K
      8'h4C: seg = 8'h1C; // L
      8'h4E: seg = 8'hEC; // N
      8'h4F: seg = 8'hFC; // O
      8'h50: seg = 8'hCE; // P
      8'h51: seg = 8'hE6; // Q
      8'h52: seg = 8'hEE; // R
      8'h53: seg = 8'hB6; // S
      8'h54: seg = 8'h1E; // T
      8'h55: seg = 8'h7C; // U
      8'h56: seg = 8'h7C; // V
      8'h58: seg = 8'h6E; // X
      8'h59: seg = 8'h66; // Y
      8'h5A: seg = 8'hDA; // Z
      8'h62: seg = 8'h3E; // b
      8'h63: seg = 8'h1A; // c
      8'h64: seg = 8'h7A; // d
      8'h67: seg = 8'hF6; // g
      8'h68: seg = 8'h2E; // h
      8'h69: seg = 8'h20; // i
      8'h6E: seg = 8'h2A; // n
      8'h6F: seg = 8'h3A; // o
      8'h72: seg = 8'h0A; // r
      8'h74: seg = 8'h1E; // t
      8'h75: seg = 8'h38; // u
      8'h76: seg = 8'h38; // v
      8'h5F: seg = 8'h10; // underscore
      8'h2D: seg = 8'h02; // minus
      default: seg = BLANK_SEG;
    endcase
    return seg;
  endfunction

endpackage

[src/ssfe_digit_store.sv]
// Digit slot store: places characters and points into slots and clears after the last beat.
module ssfe_digit_store #(
  parameter int unsigned DIGITS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ssfe_pkg::cmd_t                      cmd,
  output logic [DIGITS*ssfe_pkg::SEG_W-1:0]   digits_upd_flat
);

  localparam int unsigned CNT_W = $clog2(DIGITS + 1);

  logic [ssfe_pkg::SEG_W-1:0] digits [DIGITS];
  logic [ssfe_pkg::SEG_W-1:0] digits_next [DIGITS];
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic                       point_may_attach;
  logic                       point_may_attach_next;

  logic                       is_period;
  logic                       attach;
  logic                       slots_full;
  logic [ssfe_pkg::SEG_W-1:0] seg;

  always_comb begin
    is_period  = (cmd.char_code == ssfe_pkg::PERIOD_CODE);
    attach     = point_may_attach && (count != '0);
    slots_full = (count == CNT_W'(DIGITS));
    seg        = ssfe_pkg::seg_lookup(cmd.char_code);

    for (int i = 0; i < DIGITS; i++) begin
      digits_next[i] = digits[i];
      if (is_period) begin
        if (attach && count == CNT_W'(i + 1)) begin
          digits_next[i] = digits[i] | ssfe_pkg::POINT_SEG;
        end else if (!attach && count == CNT_W'(i)) begin
          digits_next[i] = ssfe_pkg::POINT_SEG;
        end
      end else if (count == CNT_W'(i)) begin
        digits_next[i] = seg;
      end
    end

    // A period that lights an earlier point takes no slot of its own.
    if (!slots_full && !(is_period && attach)) begin
      count_next = count + CNT_W'(1);
    end else begin
      count_next = count;
    end
    point_may_attach_next = !is_period && !slots_full;

    for (int i = 0; i < DIGITS; i++) begin
      digits_upd_flat[i*ssfe_pkg::SEG_W +: ssfe_pkg::SEG_W] = digits_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.load && cmd.last)) begin
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] <= ssfe_pkg::BLANK_SEG;
      end
      count            <= '0;
      point_may_attach <= 1'b0;
    end else if (cmd.load) begin
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] <= digits_next[i];
      end
      count            <= count_next;
      point_may_attach <= point_may_attach_next;
    end
  end

endmodule

[src/seven_segment_text_frame_encoder_unit.sv]
// Top level of the seven-segment text frame encoder: handshakes, annunciator registers, frame.
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_stall    char_code, last
//  out      source     out_valid / out_stall  frame
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One character is taken per cycle while not stalled; the frame of a beat marked last appears
// in the next cycle from the output register. The slot update and frame assembly sit in one
// combinational pass between the digit store and that register. The input stalls only while
// a frame waits in the output register and the output is stalled. Reset is synchronous and
// clears the slots, the annunciator bits and the output valid. Configuration is always ready.
module seven_segment_text_frame_encoder_unit #(
  parameter int unsigned DIGITS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ssfe_pkg::CHAR_W-1:0]       char_code,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssfe_pkg::FRAME_W-1:0]      frame,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic                              cfg_data
);

  localparam int unsigned FULL_W = DIGITS * ssfe_pkg::SEG_W + 4;

  logic                                 an1_enable;
  logic                                 an2_enable;
  logic                                 in_accept;
  ssfe_pkg::cmd_t                       cmd;
  logic [DIGITS*ssfe_pkg::SEG_W-1:0]    digits_upd_flat;
  logic [FULL_W-1:0]                    frame_full;
  logic [ssfe_pkg::FRAME_W-1:0]         frame_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign cmd.load      = in_accept;
  assign cmd.char_code = char_code;
  assign cmd.last      = last;

  ssfe_digit_store #(
    .DIGITS (DIGITS)
  ) u_store (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .digits_upd_flat (digits_upd_flat)
  );

  // Start bit, newest slot first, annunciators, stop bit.
  assign frame_full = {1'b1, digits_upd_flat, an1_enable, an2_enable, 1'b0};

  generate
    if (FULL_W >= ssfe_pkg::FRAME_W) begin : g_trunc
      assign frame_next = frame_full[ssfe_pkg::FRAME_W-1:0];
    end else begin : g_ext
      assign frame_next = {{(ssfe_pkg::FRAME_W - FULL_W){1'b0}}, frame_full};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      an1_enable <= 1'b0;
      an2_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssfe_pkg::CFG_AN1: an1_enable <= cfg_data;
        ssfe_pkg::CFG_AN2: an2_enable <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last) begin
      frame <= frame_next;
    end
  end

endmodule

[src/ssfe_checker.sv]
// Port-level checker for the text frame encoder and its bind to the top level.
module ssfe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          last,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ssfe_pkg::FRAME_W-1:0]  frame,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // A waiting frame holds until its beat is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame))
    else $error("frame changed or dropped while stalled");

  // The input backs up only behind a blocked frame.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked frame");

  // A last beat yields a frame on the next cycle, ending in a stop bit.
  a_last_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> out_valid && frame[0] == 1'b0)
    else $error("last beat did not produce a frame");

  a_out_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("frame valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind seven_segment_text_frame_encoder_unit ssfe_checker u_ssfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .frame     (frame),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

[test/tb.sv]
// Self-checking testbench for the seven-segment text frame encoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIGIT_SLOTS = 4;
  localparam int unsigned GLYPHS      = 49;
  localparam int unsigned HOLD_CYCLES = 300;

  // Known characters and their segment bytes, in matching byte positions.
  localparam logic [GLYPHS*8-1:0] GLYPH_CODES =
    " 0123456789ABCDEFGHIJKLNOPQRSTUVXYZbcdghinortuv_-";
  localparam logic [GLYPHS*8-1:0] GLYPH_SEGS = {
    88'h00_FC_60_DA_F2_66_B6_BE_E0_FE_E6,
    88'hEE_FE_9C_FC_9E_8E_BC_6E_60_70_6E,
    88'h1C_EC_FC_CE_E6_EE_B6_1E_7C_7C_6E,
    88'h66_DA_3E_1A_7A_F6_2E_20_2A_3A_0A,
    40'h1E_38_38_10_02
  };

  class frame_scoreboard;
    logic [ssfe_pkg::SEG_W-1:0]   slot_seg [DIGIT_SLOTS];
    int unsigned                  filled;
    bit                           point_ok;
    bit                           an1;
    bit                           an2;
    logic [ssfe_pkg::FRAME_W-1:0] frames_due [$];
    int unsigned                  errors;

    function new();
      an1    = 1'b0;
      an2    = 1'b0;
      errors = 0;
      clear_slots();
    endfunction

    function void clear_slots();
      foreach (slot_seg[i]) slot_seg[i] = ssfe_pkg::BLANK_SEG;
      filled   = 0;
      point_ok = 1'b0;
    endfunction

    function void set_annunciator(logic idx, logic val);
      if (idx == ssfe_pkg::CFG_AN1) begin
        an1 = val;
      end else begin
        an2 = val;
      end
    endfunction

    // Advances the digit slots by one character beat and queues the frame on the last one.
    function void note_char(logic [ssfe_pkg::CHAR_W-1:0] code, logic fin);
      logic [ssfe_pkg::SEG_W-1:0] seg;
      logic [63:0]                word;
      if (code == ssfe_pkg::PERIOD_CODE) begin
        if (point_ok && filled > 0) begin
          slot_seg[filled-1] = slot_seg[filled-1] | ssfe_pkg::POINT_SEG;
        end else if (filled < DIGIT_SLOTS) begin
          slot_seg[filled] = ssfe_pkg::POINT_SEG;
          filled++;
        end
        point_ok = 1'b0;
      end else if (filled < DIGIT_SLOTS) begin
        seg = ssfe_pkg::BLANK_SEG;
        for (int j = 0; j < GLYPHS; j++) begin
          if (GLYPH_CODES[8*j +: 8] == code) seg = GLYPH_SEGS[8*j +: 8];
        end
        slot_seg[filled] = seg;
        filled++;
        point_ok = 1'b1;
      end else begin
        point_ok = 1'b0;
      end
      if (fin) begin
        word = 64'd1;
        for (int s = DIGIT_SLOTS - 1; s >= 0; s--) word = (word << 8) | slot_seg[s];
        word = (word << 3) | {61'd0, an1, an2, 1'b0};
        frames_due.push_back(word[ssfe_pkg::FRAME_W-1:0]);
        clear_slots();
      end
    endfunction

    function void check_frame(logic [ssfe_pkg::FRAME_W-1:0] got);
      logic [ssfe_pkg::FRAME_W-1:0] want;
      if (frames_due.size() == 0) begin
        $error("frame arrived with none expected: actual %h", got);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (got !== want) begin
          $error("frame mismatch: expected %h, actual %h", want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned frames_waiting();
      return frames_due.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [ssfe_pkg::CHAR_W-1:0]  char_code = '0;
  logic                         last = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ssfe_pkg::FRAME_W-1:0] frame;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic                         cfg_index = ssfe_pkg::CFG_AN1;
  logic                         cfg_data = 1'b0;

  logic               hold_go = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        items_sent = 0;

  frame_scoreboard sb = new();

  seven_segment_text_frame_encoder_unit #(
    .DIGITS(DIGIT_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame(frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_annunciator(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_char(char_code, last);
      if (out_valid && !out_stall) sb.check_frame(frame);
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here once requested.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end else begin
      if (hold_go) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= hold_go || (hold_left > 1) || ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_beat(input logic [ssfe_pkg::CHAR_W-1:0] code, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= code;
    last      <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_beat(text[i], i == text.len() - 1);
  endtask

  // Mostly known characters and periods, with some arbitrary codes mixed in.
  task automatic send_random_text();
    int unsigned                 len;
    int unsigned                 pick;
    logic [ssfe_pkg::CHAR_W-1:0] code;
    len = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(5, 1);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        code = GLYPH_CODES[8*$urandom_range(GLYPHS - 1) +: 8];
      end else if (pick < 75) begin
        code = ssfe_pkg::PERIOD_CODE;
      end else begin
        code = ssfe_pkg::CHAR_W'($urandom_range(255));
      end
      send_beat(code, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.frames_waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic a1, input logic a2, input int unsigned idle,
                           input int unsigned stall, input int unsigned goal);
    wait_drained();
    program_reg(ssfe_pkg::CFG_AN1, a1);
    program_reg(ssfe_pkg::CFG_AN2, a2);
    send_idle_pct = idle;
    stall_pct     = stall;
    while (items_sent < goal) send_random_text();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts at the reset annunciator setting.
    send_beat(8'h00, 1'b0);
    send_beat(ssfe_pkg::PERIOD_CODE, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_text("1..7");
    send_text(".-");
    send_text("ABCD.");
    send_text("0123Z.");
    send_text(".....");

    run_phase(1'b1, 1'b0, 0, 0, 255);
    run_phase(1'b0, 1'b1, 62, 0, 485);

    // Hold the output off while frames keep coming, so the input backs up.
    wait_drained();
    stall_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 20; i++) send_beat(ssfe_pkg::CHAR_W'($urandom_range(255)), 1'b1);

    run_phase(1'b1, 1'b1, 0, 62, 735);
    run_phase(1'b0, 1'b0, 16, 16, 965);

    wait_drained();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
